/* rtl/partition_fit_allocator_assert.svh */
// ----------------------------------------------------------------------------
// Partition fit allocator assertion macros
// Clocked property wrappers used by the file that checks this block.
// ----------------------------------------------------------------------------
`ifndef PARTITION_FIT_ALLOCATOR_ASSERT_SVH
`define PARTITION_FIT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PFA_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define PFA_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/pfa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Partition fit allocator package
// Field widths, operation and policy codes, and controller/datapath links.
// ----------------------------------------------------------------------------
package pfa_pkg;

   localparam int OPCODE_W = 2;
   localparam int SEL_W    = 4;
   localparam int ADDR_W   = 16;
   localparam int PTR_W    = ADDR_W + 1;
   localparam int FREE_W   = PTR_W + 1;
   localparam int SPACE_W  = 17;
   localparam int POL_W    = 2;
   localparam int COUNT_W  = 5;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 5;

   localparam logic [OPCODE_W-1:0] OP_DEFINE = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_ALLOC  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_REWIND = 2'd2;

   localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
   localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
   localparam logic [POL_W-1:0] POL_WORST = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_FIT_POLICY = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PART_COUNT = 1'd1;

   typedef struct packed {
      logic load;
      logic issue;
      logic commit;
   } pfa_cmd_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] op;
      logic                last;
      logic                count_zero;
   } pfa_stat_type;

endpackage
`default_nettype wire

/* rtl/pfa_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Partition fit allocator request channel
// Valid/ready channel carrying one operation word.
// ----------------------------------------------------------------------------
interface pfa_req_if;
   logic                          valid;
   logic                          ready;
   logic [pfa_pkg::OPCODE_W-1:0]  opcode;
   logic [pfa_pkg::SEL_W-1:0]     part_sel;
   logic [pfa_pkg::ADDR_W-1:0]    start_addr;
   logic [pfa_pkg::ADDR_W-1:0]    end_addr;
   logic [pfa_pkg::ADDR_W-1:0]    request_size;

   modport source (output valid, opcode, part_sel, start_addr, end_addr, request_size,
                   input ready);
   modport sink (input valid, opcode, part_sel, start_addr, end_addr, request_size,
                 output ready);
endinterface
`default_nettype wire

/* rtl/pfa_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Partition fit allocator response channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface pfa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          granted;
   logic [pfa_pkg::SEL_W-1:0]     chosen_part;
   logic [pfa_pkg::ADDR_W-1:0]    alloc_addr;
   logic [pfa_pkg::SPACE_W-1:0]   space_left;

   modport source (output valid, granted, chosen_part, alloc_addr, space_left,
                   input ready);
   modport sink (input valid, granted, chosen_part, alloc_addr, space_left,
                 output ready);
endinterface
`default_nettype wire

/* rtl/pfa_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Partition fit allocator datapath
// Partition table memory, scan evaluation, pick tracking and result register.
// ----------------------------------------------------------------------------
module pfa_dp #(
   parameter int MAX_PARTS = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [pfa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [pfa_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic [pfa_pkg::OPCODE_W-1:0]    req_opcode,
   input  wire logic [pfa_pkg::SEL_W-1:0]       req_part_sel,
   input  wire logic [pfa_pkg::ADDR_W-1:0]      req_start_addr,
   input  wire logic [pfa_pkg::ADDR_W-1:0]      req_end_addr,
   input  wire logic [pfa_pkg::ADDR_W-1:0]      req_request_size,
   input  wire pfa_pkg::pfa_cmd_type            cmd,
   output pfa_pkg::pfa_stat_type                stat,
   output logic                                 rsp_granted,
   output logic [pfa_pkg::SEL_W-1:0]            rsp_chosen_part,
   output logic [pfa_pkg::ADDR_W-1:0]           rsp_alloc_addr,
   output logic [pfa_pkg::SPACE_W-1:0]          rsp_space_left
);

   localparam int IDX_W = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
   localparam int CNT_W = $clog2(MAX_PARTS + 1);
   localparam int AW    = pfa_pkg::ADDR_W;
   localparam int PW    = pfa_pkg::PTR_W;
   localparam int FW    = pfa_pkg::FREE_W;
   localparam int ROW_W = 2 * AW + PW;

   // Row layout: start, end, next free pointer.
   logic [ROW_W-1:0] mem [MAX_PARTS];

   logic [pfa_pkg::POL_W-1:0]    fit_policy_ff;
   logic [pfa_pkg::COUNT_W-1:0]  part_count_ff;

   logic [pfa_pkg::OPCODE_W-1:0] op_ff;
   logic [pfa_pkg::SEL_W-1:0]    sel_ff;
   logic [AW-1:0]                start_ff;
   logic [AW-1:0]                end_ff;
   logic [AW-1:0]                size_ff;

   logic [IDX_W-1:0]             idx_ff;
   logic [IDX_W-1:0]             eval_idx_ff;
   logic                         eval_vld_ff;
   logic [ROW_W-1:0]             rd_row_ff;

   logic                         found_ff;
   logic [IDX_W-1:0]             pick_ff;
   logic signed [FW-1:0]         pick_free_ff;
   logic [PW-1:0]                pick_base_ff;
   logic [AW-1:0]                pick_start_ff;
   logic [AW-1:0]                pick_end_ff;

   logic                         granted_ff;
   logic [pfa_pkg::SEL_W-1:0]    chosen_ff;
   logic [AW-1:0]                addr_ff;
   logic [pfa_pkg::SPACE_W-1:0]  space_ff;

   logic [AW-1:0]                rd_start;
   logic [AW-1:0]                rd_end;
   logic [PW-1:0]                rd_next;
   logic signed [FW-1:0]         rd_free;
   logic signed [FW-1:0]         size_ext;
   logic signed [FW-1:0]         left_full;
   logic                         fits;
   logic                         take;
   logic [CNT_W-1:0]             cnt_eff;
   logic [CNT_W-1:0]             scan_lim;
   logic                         sel_ok;
   logic                         rew_wr;
   logic                         def_wr;
   logic                         alloc_wr;
   logic [PW-1:0]                new_next;

   always_comb begin
      if (int'(part_count_ff) > MAX_PARTS) begin
         cnt_eff = CNT_W'(MAX_PARTS);
      end else begin
         cnt_eff = CNT_W'(part_count_ff);
      end
      scan_lim = (op_ff == pfa_pkg::OP_REWIND) ? CNT_W'(MAX_PARTS) : cnt_eff;
   end

   assign stat.op         = op_ff;
   assign stat.count_zero = (cnt_eff == '0);
   assign stat.last       = (CNT_W'(idx_ff) == (scan_lim - CNT_W'(1)));

   assign rd_start = rd_row_ff[ROW_W-1 -: AW];
   assign rd_end   = rd_row_ff[PW +: AW];
   assign rd_next  = rd_row_ff[PW-1:0];

   // Free space is signed: a partition whose end lies below its pointer never fits a nonzero size.
   assign rd_free   = $signed({2'b00, rd_end}) - $signed({1'b0, rd_next}) + FW'(1);
   assign size_ext  = $signed({2'b00, size_ff});
   assign fits      = (rd_free >= size_ext);
   assign left_full = pick_free_ff - size_ext;
   assign new_next  = pick_base_ff + {1'b0, size_ff};

   always_comb begin
      take = 1'b0;
      if (eval_vld_ff && (op_ff == pfa_pkg::OP_ALLOC) && fits) begin
         if (!found_ff) begin
            take = 1'b1;
         end else begin
            case (fit_policy_ff)
               pfa_pkg::POL_BEST:  take = (rd_free <= pick_free_ff);
               pfa_pkg::POL_WORST: take = (rd_free >= pick_free_ff);
               default:            take = 1'b0;
            endcase
         end
      end
   end

   assign sel_ok   = (int'(sel_ff) < MAX_PARTS);
   assign rew_wr   = eval_vld_ff && (op_ff == pfa_pkg::OP_REWIND);
   assign def_wr   = cmd.commit && (op_ff == pfa_pkg::OP_DEFINE) && sel_ok;
   assign alloc_wr = cmd.commit && (op_ff == pfa_pkg::OP_ALLOC) && found_ff;

   always_ff @(posedge clock) begin
      if (rew_wr) begin
         mem[eval_idx_ff] <= {rd_start, rd_end, {1'b0, rd_start}};
      end else if (def_wr) begin
         mem[IDX_W'(sel_ff)] <= {start_ff, end_ff, {1'b0, start_ff}};
      end else if (alloc_wr) begin
         mem[pick_ff] <= {pick_start_ff, pick_end_ff, new_next};
      end
      if (cmd.issue) begin
         rd_row_ff <= mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_policy_ff <= pfa_pkg::POL_FIRST;
         part_count_ff <= pfa_pkg::COUNT_W'(1);
         eval_vld_ff   <= 1'b0;
         found_ff      <= 1'b0;
         idx_ff        <= '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               pfa_pkg::CSR_FIT_POLICY: fit_policy_ff <= csr_wdata[pfa_pkg::POL_W-1:0];
               pfa_pkg::CSR_PART_COUNT: part_count_ff <= csr_wdata[pfa_pkg::COUNT_W-1:0];
               default: ;
            endcase
         end
         eval_vld_ff <= cmd.issue;
         if (cmd.load) begin
            idx_ff   <= '0;
            found_ff <= 1'b0;
         end else begin
            if (cmd.issue) begin
               idx_ff <= idx_ff + IDX_W'(1);
            end
            if (take) begin
               found_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_opcode;
         sel_ff   <= req_part_sel;
         start_ff <= req_start_addr;
         end_ff   <= req_end_addr;
         size_ff  <= req_request_size;
      end
      eval_idx_ff <= idx_ff;
      if (take) begin
         pick_ff       <= eval_idx_ff;
         pick_free_ff  <= rd_free;
         pick_base_ff  <= rd_next;
         pick_start_ff <= rd_start;
         pick_end_ff   <= rd_end;
      end
      if (cmd.commit) begin
         if (op_ff == pfa_pkg::OP_ALLOC) begin
            granted_ff <= found_ff;
            chosen_ff  <= found_ff ? pfa_pkg::SEL_W'(pick_ff) : '0;
            addr_ff    <= found_ff ? pick_base_ff[AW-1:0] : '0;
            space_ff   <= found_ff ? left_full[pfa_pkg::SPACE_W-1:0] : '0;
         end else begin
            granted_ff <= 1'b1;
            chosen_ff  <= '0;
            addr_ff    <= '0;
            space_ff   <= '0;
         end
      end
   end

   assign rsp_granted     = granted_ff;
   assign rsp_chosen_part = chosen_ff;
   assign rsp_alloc_addr  = addr_ff;
   assign rsp_space_left  = space_ff;

endmodule
`default_nettype wire

/* rtl/pfa_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Partition fit allocator controller
// Sequences accept, table scan or rewind sweep, and result hand-off.
// ----------------------------------------------------------------------------
module pfa_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic [pfa_pkg::OPCODE_W-1:0]  req_opcode,
   output logic                               req_ready,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire pfa_pkg::pfa_stat_type         stat,
   output pfa_pkg::pfa_cmd_type               cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      slot_free;
   logic      scan_needed;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Defines, unused opcodes and allocates with an empty partition range skip the table walk.
   assign scan_needed = ((req_opcode == pfa_pkg::OP_ALLOC) && !stat.count_zero) ||
                        (req_opcode == pfa_pkg::OP_REWIND);

   assign cmd.load   = (state_ff == ST_IDLE) && req_valid;
   assign cmd.issue  = (state_ff == ST_SCAN);
   assign cmd.commit = (state_ff == ST_FINISH) && slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A commit in the same cycle refills the output register instead.
         if (rsp_valid_ff && rsp_ready && !cmd.commit) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= scan_needed ? ST_SCAN : ST_FINISH;
               end
            end
            ST_SCAN: begin
               if (stat.last) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

/* rtl/partition_fit_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Partition fit allocator
// Fixed partition table with first, best and worst fit bump allocation.
// ----------------------------------------------------------------------------
// One word is worked at a time. A define or an unused opcode skips the table
// walk. An allocate walks partitions 0 to part_count-1 (at most MAX_PARTS-1)
// through the single read port of the partition table, one row a cycle; with
// a count of zero it skips the walk. A rewind copies every start address into
// its pointer, one row a cycle over the whole table. A new word is taken
// while the previous result still waits in the output register.
// The table has no reset; allocating from a partition never defined gives
// undefined results.
module partition_fit_allocator #(
   parameter int MAX_PARTS = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   pfa_req_if.sink                              req_port,
   pfa_rsp_if.source                            rsp_port,
   input  wire logic                            csr_wr_en,
   input  wire logic [pfa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [pfa_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   pfa_pkg::pfa_cmd_type  cmd;
   pfa_pkg::pfa_stat_type stat;

   pfa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_port.valid),
      .req_opcode (req_port.opcode),
      .req_ready  (req_port.ready),
      .rsp_valid  (rsp_port.valid),
      .rsp_ready  (rsp_port.ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   pfa_dp #(
      .MAX_PARTS (MAX_PARTS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_opcode       (req_port.opcode),
      .req_part_sel     (req_port.part_sel),
      .req_start_addr   (req_port.start_addr),
      .req_end_addr     (req_port.end_addr),
      .req_request_size (req_port.request_size),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_granted      (rsp_port.granted),
      .rsp_chosen_part  (rsp_port.chosen_part),
      .rsp_alloc_addr   (rsp_port.alloc_addr),
      .rsp_space_left   (rsp_port.space_left)
   );

`include "partition_fit_allocator_assert.svh"

   // A result is only written into the output register when it is free.
   `PFA_ASSERT_IMP(a_commit_slot, cmd.commit, !rsp_port.valid || rsp_port.ready, "result overwritten")

   // Once a word is taken the block is busy for at least the next cycle.
   `PFA_ASSERT_NXT(a_busy_after_load, req_port.valid && req_port.ready, !req_port.ready, "ready after load")

   // A refused allocate reports all fields as zero.
   `PFA_ASSERT_IMP(a_nofit_zero, rsp_port.valid && !rsp_port.granted, (rsp_port.chosen_part == '0) && (rsp_port.alloc_addr == '0) && (rsp_port.space_left == '0), "no-fit fields not zero")

endmodule
`default_nettype wire
